>>> src/pttp_pkg.sv
// ----------------------------------------------------------------------------
// pttp_pkg
// Shared constants and types for the pulse text to PCM run converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pttp_pkg;

  localparam int COUNT_BITS_DEF = 20;

  localparam int BYTE_BITS    = 8;
  localparam int DIV_BITS     = 16;
  localparam int LEVEL_BITS   = 8;
  localparam int RUN_BITS     = 20;
  localparam int FRAC_BITS    = 8;
  localparam int CFG_IDX_BITS = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [RUN_BITS-1:0]   RUN_MAX      = {RUN_BITS{1'b1}};
  localparam logic [DIV_BITS-1:0]   DIVISOR_RST  = 16'd2903;
  localparam logic [LEVEL_BITS-1:0] LEVEL_A_RST  = 8'hF8;
  localparam logic [LEVEL_BITS-1:0] LEVEL_B_RST  = 8'h08;

  localparam logic [BYTE_BITS-1:0]  CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_BITS-1:0]  CHAR_NINE    = 8'h39;
  localparam logic [BYTE_BITS-1:0]  CHAR_NEWLINE = 8'h0A;

  localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_A   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_B   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED    = 2'd3;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_FIN  = 3'b100
  } back_state_t;

endpackage

`default_nettype wire

>>> src/pttp_front.sv
// ----------------------------------------------------------------------------
// pttp_front
// Accepts text bytes, builds the decimal width and hands each finished line
// to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pttp_front #(
  parameter int COUNT_BITS = pttp_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           text_valid,
  output logic                                text_ready,
  input  wire logic [pttp_pkg::BYTE_BITS-1:0] text_byte,
  input  wire pttp_pkg::queue_stat_t          q_stat,
  output logic                                q_push,
  output logic [COUNT_BITS-1:0]               q_data
);
  import pttp_pkg::*;

  localparam int EXT_BITS = COUNT_BITS + 4;

  logic [COUNT_BITS-1:0] acc;
  logic [COUNT_BITS-1:0] acc_next;
  logic [EXT_BITS-1:0]   prod;
  logic                  accept;
  logic                  is_digit;
  logic                  is_newline;

  assign text_ready = !q_stat.full;
  assign accept     = text_valid && text_ready;
  assign is_digit   = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
  assign is_newline = (text_byte == CHAR_NEWLINE);

  // acc * 10 as (acc << 3) + (acc << 1), plus the digit value.
  always_comb begin
    prod = (EXT_BITS'(acc) << 3) + (EXT_BITS'(acc) << 1)
         + EXT_BITS'(text_byte - CHAR_ZERO);
    if (prod[EXT_BITS-1:COUNT_BITS] != '0) begin
      acc_next = {COUNT_BITS{1'b1}};
    end else begin
      acc_next = prod[COUNT_BITS-1:0];
    end
  end

  assign q_push = accept && is_newline;
  assign q_data = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      if (is_digit) begin
        acc <= acc_next;
      end else if (is_newline) begin
        acc <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/pttp_queue.sv
// ----------------------------------------------------------------------------
// pttp_queue
// Short first-in first-out queue of finished line widths.
// ----------------------------------------------------------------------------
`default_nettype none

module pttp_queue #(
  parameter int WIDTH = pttp_pkg::COUNT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output pttp_pkg::queue_stat_t stat
);
  import pttp_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign stat.full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem[rd_ptr];

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/pttp_back.sv
// ----------------------------------------------------------------------------
// pttp_back
// Divides each queued width by the sample divisor, carries the remainder and
// drives the result register; a zero divisor gives a run of RUN_MAX.
// ----------------------------------------------------------------------------
`default_nettype none

module pttp_back #(
  parameter int COUNT_BITS = pttp_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire pttp_pkg::queue_stat_t           q_stat,
  input  wire logic [COUNT_BITS-1:0]           q_data,
  output logic                                 q_pop,
  input  wire logic [pttp_pkg::DIV_BITS-1:0]   divisor_q8,
  input  wire logic [pttp_pkg::LEVEL_BITS-1:0] level_first,
  input  wire logic [pttp_pkg::LEVEL_BITS-1:0] level_second,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output logic [pttp_pkg::LEVEL_BITS-1:0]      sample_level,
  output logic [pttp_pkg::RUN_BITS-1:0]        run_length
);
  import pttp_pkg::*;

  localparam int NUM_BITS = COUNT_BITS + FRAC_BITS;
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);
  localparam int QW       = (NUM_BITS > RUN_BITS) ? NUM_BITS : RUN_BITS;

  back_state_t           state;
  back_state_t           state_next;
  logic [NUM_BITS-1:0]   quo;
  logic [DIV_BITS-1:0]   rem;
  logic [CNT_BITS-1:0]   cnt;
  logic                  zero_div;
  logic [DIV_BITS-1:0]   carry;
  logic                  level_flag;

  logic [DIV_BITS:0]     trial;
  logic                  trial_ge;
  logic [DIV_BITS:0]     carry_sum;
  logic                  carry_inc;
  logic [DIV_BITS-1:0]   carry_next;
  logic [QW-1:0]         quo_ext;
  logic [RUN_BITS-1:0]   run_next;
  logic                  out_load;

  // One restoring division step: bring in the next numerator bit.
  assign trial    = {rem, quo[NUM_BITS-1]};
  assign trial_ge = (trial >= {1'b0, divisor_q8});

  assign carry_sum  = {1'b0, carry} + {1'b0, rem};
  assign carry_inc  = (carry_sum >= {1'b0, divisor_q8});
  assign carry_next = carry_inc ? DIV_BITS'(carry_sum - {1'b0, divisor_q8})
                                : carry_sum[DIV_BITS-1:0];

  assign quo_ext = QW'(quo);

  always_comb begin
    if (zero_div || (quo_ext > QW'(RUN_MAX))) begin
      run_next = RUN_MAX;
    end else if (quo_ext[RUN_BITS-1:0] == RUN_MAX) begin
      run_next = RUN_MAX;
    end else begin
      run_next = quo_ext[RUN_BITS-1:0] + RUN_BITS'(carry_inc);
    end
  end

  assign out_load = (state == B_FIN) && (!result_valid || result_ready);
  assign q_pop    = (state == B_IDLE) && !q_stat.empty;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_stat.empty) begin
          state_next = (divisor_q8 == '0) ? B_FIN : B_DIV;
        end
      end
      B_DIV: begin
        if (cnt == CNT_BITS'(1)) begin
          state_next = B_FIN;
        end
      end
      B_FIN: begin
        if (out_load) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      carry        <= '0;
      level_flag   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
        level_flag   <= !level_flag;
        if (!zero_div) begin
          carry <= carry_next;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      quo      <= {q_data, {FRAC_BITS{1'b0}}};
      rem      <= '0;
      cnt      <= CNT_BITS'(NUM_BITS);
      zero_div <= (divisor_q8 == '0);
    end else if (state == B_DIV) begin
      rem <= trial_ge ? DIV_BITS'(trial - {1'b0, divisor_q8}) : trial[DIV_BITS-1:0];
      quo <= {quo[NUM_BITS-2:0], trial_ge};
      cnt <= cnt - 1'b1;
    end
    if (out_load) begin
      sample_level <= level_flag ? level_second : level_first;
      run_length   <= run_next;
    end
  end

endmodule

`default_nettype wire

>>> src/pulse_text_to_pcm_runs_top.sv
// ----------------------------------------------------------------------------
// pulse_text_to_pcm_runs_top
// Turns lines of decimal pulse widths into level and run length pairs.
// ----------------------------------------------------------------------------
// The text channel (text_valid, text_ready, text_byte) takes one ASCII byte
// per transaction. Digits extend the current width, a newline closes the line,
// and every other byte is dropped. Each newline yields one result transaction
// on result_valid/result_ready carrying sample_level and run_length.
// Digits and ignored bytes are taken whenever text_ready is high. A newline
// is queued at once; the back end then takes the line from the queue, runs
// its radix-2 restoring divider over the COUNT_BITS + 8 numerator bits
// (skipped with a zero divisor), settles the remainder carry and loads the
// result register that drives sample_level and run_length.
// The two-entry line queue lets text bytes flow while a division runs; when
// the queue is full, text_ready drops until the back end takes a line.
// If the receiver stalls, the result register holds its transaction and the
// back end waits, after which the queue and then text_ready back up.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// accepted. Reset restores the default divisor and levels, clears the width,
// carry and level flag, and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_text_to_pcm_runs_top #(
  parameter int COUNT_BITS = pttp_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              text_valid,
  output logic                                   text_ready,
  input  wire logic [pttp_pkg::BYTE_BITS-1:0]    text_byte,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic [pttp_pkg::LEVEL_BITS-1:0]        sample_level,
  output logic [pttp_pkg::RUN_BITS-1:0]          run_length,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pttp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [pttp_pkg::DIV_BITS-1:0]     cfg_data
);
  import pttp_pkg::*;

  logic [DIV_BITS-1:0]   divisor_q8;
  logic [LEVEL_BITS-1:0] level_first;
  logic [LEVEL_BITS-1:0] level_second;

  queue_stat_t           q_stat;
  logic                  q_push;
  logic                  q_pop;
  logic [COUNT_BITS-1:0] q_in;
  logic [COUNT_BITS-1:0] q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_q8   <= DIVISOR_RST;
      level_first  <= LEVEL_A_RST;
      level_second <= LEVEL_B_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIVISOR: divisor_q8   <= cfg_data;
        REG_LEVEL_A: level_first  <= cfg_data[LEVEL_BITS-1:0];
        REG_LEVEL_B: level_second <= cfg_data[LEVEL_BITS-1:0];
        REG_UNUSED:  ;
        default:     ;
      endcase
    end
  end

  pttp_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_byte  (text_byte),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  pttp_queue #(
    .WIDTH (COUNT_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  pttp_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .divisor_q8   (divisor_q8),
    .level_first  (level_first),
    .level_second (level_second),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample_level (sample_level),
    .run_length   (run_length)
  );

endmodule

`default_nettype wire

>>> tb/pulse_text_to_pcm_runs_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_text_to_pcm_runs_top_test
// Self-checking testbench for the pulse text to PCM run converter.
// ----------------------------------------------------------------------------
// Text bytes are sent as lines of decimal widths with stray bytes mixed in.
// The bench keeps its own copy of the width accumulator, remainder carry and
// level flag, and predicts a level and run length for every newline. Each
// result transaction is compared with the oldest prediction. Random gaps on
// the text side and random stalls on the result side move the handshakes
// around, and the registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------

module pulse_text_to_pcm_runs_top_test;
  import pttp_pkg::*;

  localparam int COUNT_BITS    = COUNT_BITS_DEF;
  localparam int SETTLE_CYCLES = COUNT_BITS + 20;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam logic [63:0] WIDTH_MAX = (64'd1 << COUNT_BITS) - 64'd1;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [RUN_BITS-1:0]   run;
  } run_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    text_valid   = 1'b0;
  logic                    text_ready;
  logic [BYTE_BITS-1:0]    text_byte    = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic [LEVEL_BITS-1:0]   sample_level;
  logic [RUN_BITS-1:0]     run_length;
  logic                    cfg_valid    = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
  logic [DIV_BITS-1:0]     cfg_data     = '0;

  // Bench copy of the converter state and registers.
  logic [DIV_BITS-1:0]   div_q8;
  logic [LEVEL_BITS-1:0] level_lo;
  logic [LEVEL_BITS-1:0] level_hi;
  logic [COUNT_BITS-1:0] width_acc;
  logic [DIV_BITS-1:0]   carry_q8;
  logic                  level_sel;

  run_rec_t pending_runs[$];

  int  fail_count   = 0;
  int  text_items   = 0;
  int  cycle_count  = 0;
  bit  text_gaps_on = 1'b1;
  int  stall_pct    = 25;

  pulse_text_to_pcm_runs_top #(.COUNT_BITS(COUNT_BITS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample_level (sample_level),
    .run_length   (run_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stretches of low ready.
  always @(posedge clk) begin : result_stall_gen
    int stall_left;
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else begin
      result_ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = gap_length();
    end
  end

  always @(posedge clk) begin : check_results
    run_rec_t exp_rec;
    if (!rst && result_valid && result_ready) begin
      if (pending_runs.size() == 0) begin
        $error("unexpected result: sample_level %0d run_length %0d",
               sample_level, run_length);
        fail_count++;
      end else begin
        exp_rec = pending_runs.pop_front();
        if (sample_level !== exp_rec.level) begin
          $error("sample_level mismatch: expected %0d, got %0d",
                 exp_rec.level, sample_level);
          fail_count++;
        end
        if (run_length !== exp_rec.run) begin
          $error("run_length mismatch: expected %0d, got %0d",
                 exp_rec.run, run_length);
          fail_count++;
        end
      end
    end
  end

  task automatic reset_state();
    div_q8    = DIVISOR_RST;
    level_lo  = LEVEL_A_RST;
    level_hi  = LEVEL_B_RST;
    width_acc = '0;
    carry_q8  = '0;
    level_sel = 1'b0;
  endtask

  // Advances the line state by one accepted byte and queues the run a newline
  // closes.
  task automatic track_byte(input logic [BYTE_BITS-1:0] ch);
    logic [63:0] nxt, num, quo, rem, carry;
    run_rec_t rec;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      nxt = 64'(width_acc) * 64'd10 + 64'(ch - CHAR_ZERO);
      width_acc = (nxt > WIDTH_MAX) ? WIDTH_MAX[COUNT_BITS-1:0] : nxt[COUNT_BITS-1:0];
      text_items++;
    end else if (ch == CHAR_NEWLINE) begin
      rec.level = level_sel ? level_hi : level_lo;
      if (div_q8 == '0) begin
        rec.run = RUN_MAX;
      end else begin
        num   = 64'(width_acc) << FRAC_BITS;
        quo   = num / 64'(div_q8);
        rem   = num % 64'(div_q8);
        carry = 64'(carry_q8) + rem;
        // At most one extra sample per line, even after the divisor drops.
        if (carry >= 64'(div_q8)) begin
          carry = carry - 64'(div_q8);
          quo   = quo + 64'd1;
        end
        carry_q8 = carry[DIV_BITS-1:0];
        rec.run  = (quo > 64'(RUN_MAX)) ? RUN_MAX : quo[RUN_BITS-1:0];
      end
      pending_runs.push_back(rec);
      width_acc = '0;
      level_sel = ~level_sel;
      text_items++;
    end
  endtask

  // Returns at the edge that accepted the byte, or after a random gap with valid
  // dropped; without a gap, valid stays high for the next call in the same step.
  task automatic send_byte(input logic [BYTE_BITS-1:0] ch);
    text_valid <= 1'b1;
    text_byte  <= ch;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    track_byte(ch);
    if (text_gaps_on && $urandom_range(0, 99) < 45) begin
      text_valid <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
  endtask

  task automatic text_stop();
    text_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [DIV_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DIVISOR: div_q8   = data;
      REG_LEVEL_A: level_lo = data[LEVEL_BITS-1:0];
      REG_LEVEL_B: level_hi = data[LEVEL_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    text_stop();
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_levels(input logic [LEVEL_BITS-1:0] lo,
                              input logic [LEVEL_BITS-1:0] hi);
    // Upper data bits are junk; only the low byte belongs to a level.
    write_reg(REG_LEVEL_A, {8'($urandom_range(0, 255)), lo});
    write_reg(REG_LEVEL_B, {8'($urandom_range(0, 255)), hi});
  endtask

  function automatic logic [DIV_BITS-1:0] pick_divisor();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 12) return 16'($urandom_range(1, 255));
    if (r < 18) return 16'd256;
    if (r < 24) return 16'hFFFF;
    return 16'($urandom_range(256, 65535));
  endfunction

  task automatic send_random_line();
    int r, ndig;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      if (r < 70)      ndig = $urandom_range(1, 4);
      else if (r < 90) ndig = $urandom_range(5, 7);
      else             ndig = $urandom_range(0, 10);
      for (int i = 0; i < ndig; i++) begin
        if ($urandom_range(0, 99) < 4) send_byte(8'($urandom_range(0, 255)));
        send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      send_byte(CHAR_NEWLINE);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic test_directed_lines();
    send_text("0\n");
    // All ten digits; the value saturates the accumulator.
    send_text("1234567890\n");
    // Stray bytes inside a line are dropped.
    send_byte(CHAR_ZERO + 8'd5);
    send_byte(8'h2F);
    send_byte(8'h3A);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0D);
    send_byte(8'h80);
    send_text("7\n");
    send_byte(CHAR_NEWLINE);
    send_text("1\n");
    wait_drained();
  endtask

  task automatic test_register_extremes();
    logic [DIV_BITS-1:0] divs[6] = '{16'hFFFF, 16'd256, 16'd1, 16'd0, 16'd255, DIVISOR_RST};
    write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    foreach (divs[i]) begin
      write_reg(REG_DIVISOR, divs[i]);
      case (i % 3)
        0: write_levels(8'h00, 8'hFF);
        1: write_levels(8'hFF, 8'h00);
        default: write_levels(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      repeat (4) send_random_line();
      send_text("9999999\n");
      wait_drained();
    end
  endtask

  task automatic test_random_lines();
    int goal;
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(REG_DIVISOR, pick_divisor());
      write_levels(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      text_gaps_on = (phase != 1);
      stall_pct    = (phase == 3) ? 0 : 25;
      goal = text_items + 300;
      while (text_items < goal) begin
        send_random_line();
        // In one window of items the sender holds off after each line until every pending run is out.
        if (phase == 2 && text_items >= goal - 150 && text_items < goal - 140) begin
          text_stop();
          while (pending_runs.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
      wait_drained();
    end
    text_gaps_on = 1'b1;
    stall_pct    = 25;
  endtask

  task automatic test_result_backpressure();
    int goal;
    write_reg(REG_DIVISOR, pick_divisor());
    write_levels(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    // Full-rate text against a slow receiver fills the line queue.
    text_gaps_on = 1'b0;
    stall_pct    = 70;
    goal = text_items + 250;
    while (text_items < goal) send_random_line();
    wait_drained();
    text_gaps_on = 1'b1;
    stall_pct    = 25;
  endtask

  initial begin
    reset_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_lines();
    test_register_extremes();
    test_random_lines();
    test_result_backpressure();
    wait_drained();
    if (fail_count == 0 && pending_runs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
src/pttp_pkg.sv
src/pttp_front.sv
src/pttp_queue.sv
src/pttp_back.sv
src/pulse_text_to_pcm_runs_top.sv
tb/pulse_text_to_pcm_runs_top_test.sv
